>>> rtl/cs_pkg.sv
// Package for circle_sort: microcode types, control program and shared constants.
package cs_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int VALUE_WIDTH_DEF  = 32;

    // Range stack: eight entries, pointer counts up to the full mark.
    localparam int STACK_DEPTH = 8;
    localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] upc_t;

    // Datapath action per step.
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_PASS_INIT,
        ACT_POP,
        ACT_CMP,
        ACT_WB,
        ACT_MID,
        ACT_PUSH_HI,
        ACT_PUSH_LO,
        ACT_EMIT_INIT,
        ACT_EMIT,
        ACT_CLEAR
    } act_t;

    // Sequencing mode: fall through, conditional jump, or hold until true.
    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_JUMP,
        SEQ_WAIT
    } seq_t;

    typedef enum logic [3:0] {
        COND_ALWAYS,
        COND_SET_END,
        COND_SINGLE,
        COND_STACK_EMPTY,
        COND_PAIR_DONE,
        COND_NOT_ODD,
        COND_SWAPPED,
        COND_OUT_FREE,
        COND_MORE_OUT
    } cond_t;

    typedef struct packed {
        act_t  act;
        seq_t  mode;
        cond_t cond;
        upc_t  target;
    } cs_ctl_t;

    typedef struct packed {
        logic set_end;      // closing transaction of a data set accepted
        logic single;       // set holds one element
        logic stack_empty;
        logic pair_done;    // mirrored walk has met or crossed
        logic not_odd;      // no middle element left over
        logic swapped;      // current pass swapped something
        logic out_free;     // output register can take a value
        logic more_out;     // last loaded result was not the final one
    } cs_flags_t;

    // Program labels.
    localparam upc_t UPC_LOAD      = 5'd0;
    localparam upc_t UPC_CHECK     = 5'd1;
    localparam upc_t UPC_PASS_INIT = 5'd2;
    localparam upc_t UPC_POP_TEST  = 5'd3;
    localparam upc_t UPC_POP       = 5'd4;
    localparam upc_t UPC_PAIR_TEST = 5'd5;
    localparam upc_t UPC_PAIR_CMP  = 5'd6;
    localparam upc_t UPC_PAIR_WB   = 5'd7;
    localparam upc_t UPC_MID       = 5'd8;
    localparam upc_t UPC_MID_RD    = 5'd9;
    localparam upc_t UPC_MID_CMP   = 5'd10;
    localparam upc_t UPC_MID_WB    = 5'd11;
    localparam upc_t UPC_PUSH_HI   = 5'd12;
    localparam upc_t UPC_PUSH_LO   = 5'd13;
    localparam upc_t UPC_PASS_END  = 5'd14;
    localparam upc_t UPC_EMIT_INIT = 5'd15;
    localparam upc_t UPC_EMIT_RD   = 5'd16;
    localparam upc_t UPC_EMIT_OUT  = 5'd17;
    localparam upc_t UPC_EMIT_NEXT = 5'd18;
    localparam upc_t UPC_DONE      = 5'd19;

    function automatic cs_ctl_t uword(input act_t act, input seq_t mode,
                                      input cond_t cond, input upc_t target);
        cs_ctl_t w;
        w.act    = act;
        w.mode   = mode;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // Control store.
    function automatic cs_ctl_t cs_rom(input upc_t upc);
        cs_ctl_t w;
        unique case (upc)
            UPC_LOAD:      w = uword(ACT_LOAD,      SEQ_WAIT, COND_SET_END,     UPC_LOAD);
            UPC_CHECK:     w = uword(ACT_NONE,      SEQ_JUMP, COND_SINGLE,      UPC_EMIT_INIT);
            UPC_PASS_INIT: w = uword(ACT_PASS_INIT, SEQ_NEXT, COND_ALWAYS,      UPC_LOAD);
            UPC_POP_TEST:  w = uword(ACT_NONE,      SEQ_JUMP, COND_STACK_EMPTY, UPC_PASS_END);
            UPC_POP:       w = uword(ACT_POP,       SEQ_NEXT, COND_ALWAYS,      UPC_LOAD);
            UPC_PAIR_TEST: w = uword(ACT_NONE,      SEQ_JUMP, COND_PAIR_DONE,   UPC_MID);
            UPC_PAIR_CMP:  w = uword(ACT_CMP,       SEQ_NEXT, COND_ALWAYS,      UPC_LOAD);
            UPC_PAIR_WB:   w = uword(ACT_WB,        SEQ_JUMP, COND_ALWAYS,      UPC_PAIR_TEST);
            UPC_MID:       w = uword(ACT_MID,       SEQ_JUMP, COND_NOT_ODD,     UPC_PUSH_HI);
            UPC_MID_RD:    w = uword(ACT_NONE,      SEQ_NEXT, COND_ALWAYS,      UPC_LOAD);
            UPC_MID_CMP:   w = uword(ACT_CMP,       SEQ_NEXT, COND_ALWAYS,      UPC_LOAD);
            UPC_MID_WB:    w = uword(ACT_WB,        SEQ_NEXT, COND_ALWAYS,      UPC_LOAD);
            UPC_PUSH_HI:   w = uword(ACT_PUSH_HI,   SEQ_NEXT, COND_ALWAYS,      UPC_LOAD);
            UPC_PUSH_LO:   w = uword(ACT_PUSH_LO,   SEQ_JUMP, COND_ALWAYS,      UPC_POP_TEST);
            UPC_PASS_END:  w = uword(ACT_NONE,      SEQ_JUMP, COND_SWAPPED,     UPC_PASS_INIT);
            UPC_EMIT_INIT: w = uword(ACT_EMIT_INIT, SEQ_NEXT, COND_ALWAYS,      UPC_LOAD);
            UPC_EMIT_RD:   w = uword(ACT_NONE,      SEQ_NEXT, COND_ALWAYS,      UPC_LOAD);
            UPC_EMIT_OUT:  w = uword(ACT_EMIT,      SEQ_WAIT, COND_OUT_FREE,    UPC_LOAD);
            UPC_EMIT_NEXT: w = uword(ACT_NONE,      SEQ_JUMP, COND_MORE_OUT,    UPC_EMIT_RD);
            UPC_DONE:      w = uword(ACT_CLEAR,     SEQ_JUMP, COND_ALWAYS,      UPC_LOAD);
            default:       w = uword(ACT_NONE,      SEQ_JUMP, COND_ALWAYS,      UPC_LOAD);
        endcase
        return w;
    endfunction

endpackage

>>> rtl/cs_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module cs_ram
    #(
        parameter int WIDTH = 32,
        parameter int DEPTH = 64
    )
    (
        input  logic                     clk,
        input  logic                     we,
        input  logic [$clog2(DEPTH)-1:0] waddr,
        input  logic [WIDTH-1:0]         wdata,
        input  logic [$clog2(DEPTH)-1:0] raddr0,
        input  logic [$clog2(DEPTH)-1:0] raddr1,
        output logic [WIDTH-1:0]         rdata0,
        output logic [WIDTH-1:0]         rdata1
    );

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata0 <= mem_reg[raddr0];
        rdata1 <= mem_reg[raddr1];
    end

endmodule

>>> rtl/cs_seq.sv
// Microcode sequencer: step counter, control store lookup and branch logic.
module cs_seq
    import cs_pkg::*;
    (
        input  logic      clk,
        input  logic      rst_n,
        input  cs_flags_t flags,
        output cs_ctl_t   ctl
    );

    upc_t upc_reg;
    upc_t upc_next;
    logic cond_hit;

    assign ctl = cs_rom(upc_reg);

    always_comb
    begin
        unique case (ctl.cond)
            COND_ALWAYS:      cond_hit = 1'b1;
            COND_SET_END:     cond_hit = flags.set_end;
            COND_SINGLE:      cond_hit = flags.single;
            COND_STACK_EMPTY: cond_hit = flags.stack_empty;
            COND_PAIR_DONE:   cond_hit = flags.pair_done;
            COND_NOT_ODD:     cond_hit = flags.not_odd;
            COND_SWAPPED:     cond_hit = flags.swapped;
            COND_OUT_FREE:    cond_hit = flags.out_free;
            COND_MORE_OUT:    cond_hit = flags.more_out;
            default:          cond_hit = 1'b0;
        endcase

        unique case (ctl.mode)
            SEQ_NEXT: upc_next = upc_reg + 1'b1;
            SEQ_JUMP: upc_next = cond_hit ? ctl.target : upc_reg + 1'b1;
            SEQ_WAIT: upc_next = cond_hit ? upc_reg + 1'b1 : upc_reg;
            default:  upc_next = UPC_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UPC_LOAD;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

>>> rtl/circle_sort.sv
// circle_sort: collects a data set, circle-sorts it ascending, streams it out.
//
// Input stream (s_axis_*): one signed value per transaction, tlast marks the
// final element of a set. A set also closes when it reaches MAX_ELEMENTS.
// Output stream (m_axis_*): the set in ascending order, tlast on the final one.
// Loading writes each accepted transaction into the element RAM. The sort then
// runs from a small microcode program over a dual-read, single-write element
// RAM: each compare-swap is a range test with read, a compare with first write
// and a second write; each range adds stack work, plus a read, a compare and a
// write for the middle comparison of an odd range; and passes repeat until one
// makes no swap. A set of one element skips the sort. Results then leave one at
// a time, each read from the RAM and then loaded into the output register.
// s_axis_tready is high only while loading. The output register holds a
// result until it is taken; while the receiver stalls the program waits.
// After the final result is loaded the program empties the set and returns to loading.
// Reset (rst_n, asynchronous) empties the set and the output register.
module circle_sort
    import cs_pkg::*;
    #(
        parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
        parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF,
        localparam int DATA_W      = ((VALUE_WIDTH + 7) / 8) * 8
    )
    (
        input  logic              clk,
        input  logic              rst_n,
        input  logic              s_axis_tvalid,
        output logic              s_axis_tready,
        input  logic [DATA_W-1:0] s_axis_tdata,   // [VALUE_WIDTH-1:0] value
        input  logic              s_axis_tlast,   // last
        output logic              m_axis_tvalid,
        input  logic              m_axis_tready,
        output logic [DATA_W-1:0] m_axis_tdata,   // [VALUE_WIDTH-1:0] sorted_value
        output logic              m_axis_tlast    // last_out
    );

    localparam int IDX_W   = $clog2(MAX_ELEMENTS);
    localparam int COUNT_W = $clog2(MAX_ELEMENTS + 1);

    cs_ctl_t   ctl;
    cs_flags_t flags;

    // Element count, range bounds and the two walking indices.
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0]   lo_reg, lo_next;
    logic [IDX_W-1:0]   hi_reg, hi_next;
    logic [IDX_W-1:0]   a_reg, a_next;
    logic [IDX_W-1:0]   b_reg, b_next;
    logic               swapped_reg, swapped_next;
    logic               gt_reg, gt_next;
    logic [VALUE_WIDTH-1:0] hold_reg, hold_next;

    // Range stack, each entry {lo, hi}.
    logic [2*IDX_W-1:0]     stack_reg [STACK_DEPTH];
    logic [SP_W-1:0]        sp_reg, sp_next;
    logic [SP_W-1:0]        sp_m1;
    logic                   sp_full;
    logic                   stack_we;
    logic [STACK_IDX_W-1:0] stack_widx;
    logic [2*IDX_W-1:0]     stack_wdata;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] out_data_reg, out_data_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_free;

    // Element RAM.
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [VALUE_WIDTH-1:0] rd0, rd1;

    logic             in_acc;
    logic             greater;
    logic [IDX_W:0]   mid_sum;
    logic [IDX_W-1:0] mid;
    logic [IDX_W-1:0] mid_p1;

    cs_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctl   (ctl)
    );

    // Reads always follow the walking indices; emit reuses index a.
    cs_ram
    #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_ELEMENTS)
    )
    u_ram
    (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr0 (a_reg),
        .raddr1 (b_reg),
        .rdata0 (rd0),
        .rdata1 (rd1)
    );

    assign s_axis_tready = (ctl.act == ACT_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign greater       = $signed(rd0) > $signed(rd1);
    assign mid_sum       = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid           = mid_sum[IDX_W:1];
    assign mid_p1        = mid + 1'b1;
    assign sp_m1         = sp_reg - 1'b1;
    assign sp_full       = (sp_reg == SP_W'(STACK_DEPTH));

    assign flags.set_end     = in_acc &&
                               (s_axis_tlast || cnt_reg == COUNT_W'(MAX_ELEMENTS - 1));
    assign flags.single      = (cnt_reg == COUNT_W'(1));
    assign flags.stack_empty = (sp_reg == '0);
    assign flags.pair_done   = !(a_reg < b_reg);
    assign flags.not_odd     = (a_reg != b_reg);
    assign flags.swapped     = swapped_reg;
    assign flags.out_free    = out_free;
    assign flags.more_out    = !out_last_reg;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_W'(out_data_reg);
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        cnt_next       = cnt_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        swapped_next   = swapped_reg;
        gt_next        = gt_reg;
        hold_next      = hold_reg;
        sp_next        = sp_reg;
        stack_we       = 1'b0;
        stack_widx     = sp_reg[STACK_IDX_W-1:0];
        stack_wdata    = '0;
        ram_we         = 1'b0;
        ram_waddr      = a_reg;
        ram_wdata      = rd1;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        unique case (ctl.act)
            ACT_LOAD:
            begin
                if (in_acc)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg[IDX_W-1:0];
                    ram_wdata = s_axis_tdata[VALUE_WIDTH-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            ACT_PASS_INIT:
            begin
                // Whole set as the first range.
                swapped_next = 1'b0;
                stack_we     = 1'b1;
                stack_widx   = '0;
                stack_wdata  = {IDX_W'(0), IDX_W'(cnt_reg - 1'b1)};
                sp_next      = SP_W'(1);
            end
            ACT_POP:
            begin
                sp_next = sp_m1;
                {lo_next, hi_next} = stack_reg[sp_m1[STACK_IDX_W-1:0]];
                {a_next, b_next}   = stack_reg[sp_m1[STACK_IDX_W-1:0]];
            end
            ACT_CMP:
            begin
                // Lower slot takes the smaller value now, upper slot next step.
                hold_next = rd0;
                gt_next   = greater;
                if (greater)
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = a_reg;
                    ram_wdata    = rd1;
                    swapped_next = 1'b1;
                end
            end
            ACT_WB:
            begin
                if (gt_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = b_reg;
                    ram_wdata = hold_reg;
                end
                a_next = a_reg + 1'b1;
                b_next = b_reg - 1'b1;
            end
            ACT_MID:
            begin
                // Middle element against its right neighbor (odd ranges only).
                a_next = mid;
                b_next = mid_p1;
            end
            ACT_PUSH_HI:
            begin
                if (mid_p1 < hi_reg && !sp_full)
                begin
                    stack_we    = 1'b1;
                    stack_wdata = {mid_p1, hi_reg};
                    sp_next     = sp_reg + 1'b1;
                end
            end
            ACT_PUSH_LO:
            begin
                if (lo_reg < mid && !sp_full)
                begin
                    stack_we    = 1'b1;
                    stack_wdata = {lo_reg, mid};
                    sp_next     = sp_reg + 1'b1;
                end
            end
            ACT_EMIT_INIT:
            begin
                a_next = '0;
            end
            ACT_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd0;
                    out_last_next  = (COUNT_W'(a_reg) == cnt_reg - 1'b1);
                    a_next         = a_reg + 1'b1;
                end
            end
            ACT_CLEAR:
            begin
                cnt_next     = '0;
                swapped_next = 1'b0;
            end
            ACT_NONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            sp_reg        <= '0;
            swapped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            sp_reg        <= sp_next;
            swapped_reg   <= swapped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        gt_reg       <= gt_next;
        hold_reg     <= hold_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        if (stack_we)
        begin
            stack_reg[stack_widx] <= stack_wdata;
        end
    end

`ifndef SYNTH
    // The range stack never runs past its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
    else $error("range stack pointer past depth");

    // A transaction is only taken while the store has room.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> (cnt_reg < COUNT_W'(MAX_ELEMENTS)))
    else $error("element taken with full store");

    // Compares only touch loaded entries, lower index first.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.act == ACT_CMP) |-> ((a_reg < b_reg) && (COUNT_W'(b_reg) < cnt_reg)))
    else $error("compare outside the loaded set");

    // Once the final result is loaded the block goes back to loading.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.act == ACT_CLEAR) |=> (cnt_reg == '0 && s_axis_tready))
    else $error("set not cleared after emit");
`endif

endmodule
